/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WTSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wtsp_pkg.sv */
// ----------------------------------------------------------------------------
// wtsp_pkg
// Types, widths and helpers shared by the projection block.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int NUM_COEFS   = 12;
  localparam int ROW_LEN     = 4;
  localparam int NUM_ROWS    = 3;
  localparam int COEF_IDX_W  = 4;
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 13;
  localparam int PROD_W      = 64;
  localparam int ACC_W       = 58;
  localparam int MAG_W       = 57;
  localparam int DIV_STEPS   = 49;
  localparam int DIV_LAT     = DIV_STEPS + 1;
  localparam int NLO_W       = DIV_STEPS - 32;
  localparam int NDC_W       = DIV_STEPS + 2;
  localparam int MUL_W       = NDC_W + SIZE_W + 1;
  localparam int SCR_W       = MUL_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd800;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd600;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_e;

  // One queued request between the front and the back.
  typedef struct packed {
    logic                     is_load;
    logic [COEF_IDX_W-1:0]    idx;
    logic signed [DATA_W-1:0] coef;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
  } queue_item_t;

  // Head of the queue as the back part sees it.
  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SCR_W-1:0] v);
    logic signed [SCR_W-1:0] hi;
    logic signed [SCR_W-1:0] lo;
    logic signed [DATA_W-1:0] res;
    hi = $signed({{(SCR_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
    lo = $signed({{(SCR_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
    if (v > hi) begin
      res = hi[DATA_W-1:0];
    end else if (v < lo) begin
      res = lo[DATA_W-1:0];
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/wtsp_if.sv */
// ----------------------------------------------------------------------------
// wtsp channel interfaces
// Point input, screen result and configuration write channels.
// ----------------------------------------------------------------------------
interface wtsp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic [wtsp_pkg::COEF_IDX_W-1:0]         coef_index;
  logic signed [wtsp_pkg::DATA_W-1:0]      coef_value;
  logic signed [wtsp_pkg::DATA_W-1:0]      pos_x;
  logic signed [wtsp_pkg::DATA_W-1:0]      pos_y;
  logic signed [wtsp_pkg::DATA_W-1:0]      pos_z;

  modport source (output valid, op, coef_index, coef_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, op, coef_index, coef_value, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface wtsp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wtsp_pkg::DATA_W-1:0] screen_x;
  logic signed [wtsp_pkg::DATA_W-1:0] screen_y;
  logic signed [wtsp_pkg::DATA_W-1:0] clip_w;
  logic                               zero_w;

  modport source (output valid, screen_x, screen_y, clip_w, zero_w, input ready);
  modport sink   (input valid, screen_x, screen_y, clip_w, zero_w, output ready);
endinterface

interface wtsp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wtsp_pkg::CFG_IDX_W-1:0]     index;
  logic [wtsp_pkg::SIZE_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of world points to saturated Q16.16 pixel positions.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled and
// returns one result per projected point; a coefficient load returns nothing.
// The two pipelined dividers, which form one quotient bit per stage over 49
// stages, sit between the dot-product stages in front and the viewport
// scaling behind them. Loads and projections keep their order: a projection
// always uses the coefficients loaded before it. The output register holds
// a result while the sink stalls, and a two-entry request queue keeps the
// input side open meanwhile until it is full.
module world_to_screen_projection (
  input  logic       clk_i,
  input  logic       rst_ni,
  wtsp_in_if.sink    in_i,
  wtsp_out_if.source out_o,
  wtsp_cfg_if.sink   cfg_i
);

  logic [wtsp_pkg::SIZE_W-1:0] width_q, width_d;
  logic [wtsp_pkg::SIZE_W-1:0] height_q, height_d;
  wtsp_pkg::queue_head_t head;
  logic pop;

  // Configuration writes are always taken; the user must change the viewport size only
  // while no request is in flight (the block does not enforce it), as the pipeline reads it live.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        wtsp_pkg::CFG_SCREEN_WIDTH:  width_d  = cfg_i.data;
        wtsp_pkg::CFG_SCREEN_HEIGHT: height_d = cfg_i.data;
        default: begin
          width_d  = width_q;
          height_d = height_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wtsp_pkg::WIDTH_RESET;
      height_q <= wtsp_pkg::HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // The front classifies requests and queues them.
  wtsp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // The back carries out loads and projections in queue order.
  wtsp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .out_o           (out_o)
  );

endmodule

/* hdl/wtsp_front.sv */
// ----------------------------------------------------------------------------
// wtsp_front
// Accepts requests, drops loads to slots that do not exist, and queues the
// rest in a short queue for the back part.
// ----------------------------------------------------------------------------
module wtsp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wtsp_in_if.sink               in_i,
  output wtsp_pkg::queue_head_t head_o,
  input  logic                  pop_i
);

  wtsp_pkg::queue_item_t mem_q [wtsp_pkg::QUEUE_DEPTH];
  logic [wtsp_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [wtsp_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [wtsp_pkg::QCNT_W-1:0] count_q, count_d;
  logic accept, push, pop;
  wtsp_pkg::queue_item_t item;

  assign in_i.ready = (count_q != wtsp_pkg::QCNT_W'(wtsp_pkg::QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && ((in_i.op == wtsp_pkg::OP_PROJECT) ||
                                 (in_i.coef_index < wtsp_pkg::COEF_IDX_W'(wtsp_pkg::NUM_COEFS)));
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    item.is_load = (in_i.op == wtsp_pkg::OP_LOAD);
    item.idx     = in_i.coef_index;
    item.coef    = in_i.coef_value;
    item.px      = in_i.pos_x;
    item.py      = in_i.pos_y;
    item.pz      = in_i.pos_z;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

/* hdl/wtsp_div.sv */
// ----------------------------------------------------------------------------
// wtsp_div
// Pipelined restoring divider: one quotient bit per stage, signed result
// with 32 fraction bits, clamped when the integer part overflows.
// ----------------------------------------------------------------------------
module wtsp_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [wtsp_pkg::MAG_W-1:0]          rem_i,
  input  logic [wtsp_pkg::MAG_W-1:0]          den_i,
  input  logic [wtsp_pkg::NLO_W-1:0]          nlo_i,
  input  logic                                cap_i,
  input  logic                                neg_i,
  output logic signed [wtsp_pkg::NDC_W-1:0]   quo_o
);

  localparam int Steps = wtsp_pkg::DIV_STEPS;
  localparam int MagW  = wtsp_pkg::MAG_W;

  logic [MagW-1:0]  r_q   [Steps];
  logic [MagW-1:0]  d_q   [Steps];
  logic [Steps-1:0] n_q   [Steps];
  logic [Steps-1:0] q_q   [Steps];
  logic             cap_q [Steps];
  logic             neg_q [Steps];
  logic signed [wtsp_pkg::NDC_W-1:0] quo_q;
  logic [wtsp_pkg::NDC_W-1:0] mag;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [MagW-1:0]  r_in, d_in;
    logic [Steps-1:0] n_in, q_in;
    logic             cap_in, neg_in, fit;
    logic [MagW:0]    trial;

    if (s == 0) begin : g_first
      assign r_in   = rem_i;
      assign d_in   = den_i;
      assign n_in   = {nlo_i, {(Steps-wtsp_pkg::NLO_W){1'b0}}};
      assign q_in   = '0;
      assign cap_in = cap_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign r_in   = r_q[s-1];
      assign d_in   = d_q[s-1];
      assign n_in   = n_q[s-1];
      assign q_in   = q_q[s-1];
      assign cap_in = cap_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    assign trial = {r_in, n_in[Steps-1]};
    assign fit   = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= fit ? MagW'(trial - {1'b0, d_in}) : trial[MagW-1:0];
        d_q[s]   <= d_in;
        n_q[s]   <= {n_in[Steps-2:0], 1'b0};
        q_q[s]   <= {q_in[Steps-2:0], fit};
        cap_q[s] <= cap_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  assign mag = cap_q[Steps-1] ? (wtsp_pkg::NDC_W'(1) << Steps)
                              : wtsp_pkg::NDC_W'(q_q[Steps-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[Steps-1] ? -$signed(mag) : $signed(mag);
    end
  end

  assign quo_o = quo_q;

endmodule

/* hdl/wtsp_back.sv */
// ----------------------------------------------------------------------------
// wtsp_back
// Executes queued requests: coefficient loads, the three dot products, the
// two divides and the viewport mapping, with an output register.
// ----------------------------------------------------------------------------
module wtsp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wtsp_pkg::queue_head_t         head_i,
  output logic                          pop_o,
  input  logic [wtsp_pkg::SIZE_W-1:0]   screen_width_i,
  input  logic [wtsp_pkg::SIZE_W-1:0]   screen_height_i,
  wtsp_out_if.source                    out_o
);

  localparam int AccW  = wtsp_pkg::ACC_W;
  localparam int MagW  = wtsp_pkg::MAG_W;
  localparam int ScrW  = wtsp_pkg::SCR_W;
  localparam int MulW  = wtsp_pkg::MUL_W;
  localparam int DataW = wtsp_pkg::DATA_W;
  localparam int Rows  = wtsp_pkg::NUM_ROWS;
  localparam int Lat   = wtsp_pkg::DIV_LAT;
  localparam logic signed [ScrW-1:0] RndX = ScrW'(65'sd4295032832);
  localparam logic signed [ScrW-1:0] RndY = ScrW'(-65'sd4294901760);

  logic en, load_wr;
  logic signed [DataW-1:0] coef_q [wtsp_pkg::NUM_COEFS];
  logic signed [DataW-1:0] pos [Rows];

  // Stage 1: products
  logic                     v1_q;
  logic signed [wtsp_pkg::PROD_W-1:0] prod_q [Rows][Rows];
  logic signed [DataW-1:0]  bias_q [Rows];
  // Stage 2 and 3: sums
  logic                     v2_q, v3_q;
  logic signed [AccW-1:0]   pa_q [Rows];
  logic signed [AccW-1:0]   pb_q [Rows];
  logic signed [AccW-1:0]   sum_q [Rows];
  // Stage 4: magnitudes
  logic                     v4_q, zero4_q, negx4_q, negy4_q;
  logic [MagW-1:0]          magx_q, magy_q, magw_q;
  logic signed [DataW-1:0]  clip4_q;
  logic signed [AccW-1:0]   clip_rnd;
  // Stage 5: overflow test and divider seed
  logic                     v5_q, zero5_q, negx5_q, negy5_q, capx_q, capy_q;
  logic [MagW-1:0]          remx_q, remy_q, den_q;
  logic [wtsp_pkg::NLO_W-1:0] nlox_q, nloy_q;
  logic signed [DataW-1:0]  clip5_q;
  // Side chain alongside the divider
  logic                     vd_q    [Lat];
  logic                     zerod_q [Lat];
  logic signed [DataW-1:0]  clipd_q [Lat];
  logic signed [wtsp_pkg::NDC_W-1:0] quox, quoy;
  // Scale stage
  logic                     vm_q, zerom_q;
  logic signed [DataW-1:0]  clipm_q;
  logic signed [MulW-1:0]   mulx_q, muly_q;
  logic signed [ScrW-1:0]   sx, sy;
  // Output register
  logic                     out_valid_q;
  logic signed [DataW-1:0]  sx_q, sy_q, cw_q;
  logic                     zw_q;

  assign en      = !out_valid_q || out_o.ready;
  assign pop_o   = head_i.valid && en;
  assign load_wr = pop_o && head_i.item.is_load;

  assign pos[0] = head_i.item.px;
  assign pos[1] = head_i.item.py;
  assign pos[2] = head_i.item.pz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wtsp_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (load_wr) begin
      coef_q[head_i.item.idx] <= head_i.item.coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      vm_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Lat; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q        <= pop_o && !head_i.item.is_load;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      vd_q[0]     <= v5_q;
      for (int i = 1; i < Lat; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
      vm_q        <= vd_q[Lat-1];
      out_valid_q <= vm_q;
    end
  end

  assign clip_rnd = (sum_q[2] + AccW'(32768)) >>> 16;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: nine products and the translation terms.
      for (int r = 0; r < Rows; r++) begin
        for (int k = 0; k < Rows; k++) begin
          prod_q[r][k] <= wtsp_pkg::PROD_W'(coef_q[r*wtsp_pkg::ROW_LEN+k]) *
                          wtsp_pkg::PROD_W'(pos[k]);
        end
        bias_q[r] <= coef_q[r*wtsp_pkg::ROW_LEN+3];
      end
      // Stage 2: floor each product to Q.32 and add in pairs.
      for (int r = 0; r < Rows; r++) begin
        pa_q[r] <= AccW'(prod_q[r][0] >>> 8) + AccW'(prod_q[r][1] >>> 8);
        pb_q[r] <= AccW'(prod_q[r][2] >>> 8) +
                   $signed({{(AccW-DataW-8){bias_q[r][DataW-1]}}, bias_q[r], 8'd0});
      end
      // Stage 3: row sums.
      for (int r = 0; r < Rows; r++) begin
        sum_q[r] <= pa_q[r] + pb_q[r];
      end
      // Stage 4: signs, magnitudes, zero test and the rounded w.
      magx_q  <= sum_q[0][AccW-1] ? MagW'(-sum_q[0]) : MagW'(sum_q[0]);
      magy_q  <= sum_q[1][AccW-1] ? MagW'(-sum_q[1]) : MagW'(sum_q[1]);
      magw_q  <= sum_q[2][AccW-1] ? MagW'(-sum_q[2]) : MagW'(sum_q[2]);
      negx4_q <= sum_q[0][AccW-1] ^ sum_q[2][AccW-1];
      negy4_q <= sum_q[1][AccW-1] ^ sum_q[2][AccW-1];
      zero4_q <= (sum_q[2] == '0);
      clip4_q <= wtsp_pkg::sat32(ScrW'(clip_rnd));
      // Stage 5: integer-part overflow test and divider seed.
      capx_q  <= ({{wtsp_pkg::NLO_W{1'b0}}, magx_q} >= {magw_q, {wtsp_pkg::NLO_W{1'b0}}});
      capy_q  <= ({{wtsp_pkg::NLO_W{1'b0}}, magy_q} >= {magw_q, {wtsp_pkg::NLO_W{1'b0}}});
      remx_q  <= magx_q >> wtsp_pkg::NLO_W;
      remy_q  <= magy_q >> wtsp_pkg::NLO_W;
      nlox_q  <= magx_q[wtsp_pkg::NLO_W-1:0];
      nloy_q  <= magy_q[wtsp_pkg::NLO_W-1:0];
      den_q   <= magw_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      zero5_q <= zero4_q;
      clip5_q <= clip4_q;
      // Side chain.
      zerod_q[0] <= zero5_q;
      clipd_q[0] <= clip5_q;
      for (int i = 1; i < Lat; i++) begin
        zerod_q[i] <= zerod_q[i-1];
        clipd_q[i] <= clipd_q[i-1];
      end
      // Scale by the viewport size.
      mulx_q  <= MulW'(quox) * MulW'($signed({1'b0, screen_width_i}));
      muly_q  <= MulW'(quoy) * MulW'($signed({1'b0, screen_height_i}));
      zerom_q <= zerod_q[Lat-1];
      clipm_q <= clipd_q[Lat-1];
      // Output register.
      sx_q <= zerom_q ? '0 : wtsp_pkg::sat32(sx >>> 17);
      sy_q <= zerom_q ? '0 : wtsp_pkg::sat32(sy >>> 17);
      cw_q <= zerom_q ? '0 : clipm_q;
      zw_q <= zerom_q;
    end
  end

  // Viewport mapping at 33 fraction bits, with the pixel-center offset and
  // the half-up rounding term folded into one constant per axis.
  assign sx = $signed({{(ScrW-wtsp_pkg::SIZE_W-32){1'b0}}, screen_width_i, 32'd0}) +
              ScrW'(mulx_q) + RndX;
  assign sy = $signed({{(ScrW-wtsp_pkg::SIZE_W-32){1'b0}}, screen_height_i, 32'd0}) -
              ScrW'(muly_q) + RndY;

  wtsp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remx_q),
    .den_i (den_q),
    .nlo_i (nlox_q),
    .cap_i (capx_q),
    .neg_i (negx5_q),
    .quo_o (quox)
  );

  wtsp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remy_q),
    .den_i (den_q),
    .nlo_i (nloy_q),
    .cap_i (capy_q),
    .neg_i (negy5_q),
    .quo_o (quoy)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.screen_x = sx_q;
  assign out_o.screen_y = sy_q;
  assign out_o.clip_w   = cw_q;
  assign out_o.zero_w   = zw_q;

endmodule

/* hdl/wtsp_checker.sv */
// ----------------------------------------------------------------------------
// wtsp_checker
// Port-level checks on the projection block's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wtsp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [wtsp_pkg::DATA_W-1:0] screen_x,
  input logic signed [wtsp_pkg::DATA_W-1:0] screen_y,
  input logic signed [wtsp_pkg::DATA_W-1:0] clip_w,
  input logic                              zero_w
);

  // A stalled result stays put.
  `WTSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(screen_x) && $stable(screen_y) && $stable(clip_w) && $stable(zero_w), "stalled result changed")

  // A zero w result carries zero coordinates.
  `WTSP_ASSERT_IMPL(a_zero_w, clk_i, rst_ni, out_valid && zero_w, screen_x == '0 && screen_y == '0 && clip_w == '0, "zero w result with nonzero fields")

  // Nothing comes out right after reset.
  `WTSP_ASSERT_IMPL(a_reset_quiet, clk_i, rst_ni, $rose(rst_ni), !out_valid, "result right after reset")

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .screen_x  (out_o.screen_x),
  .screen_y  (out_o.screen_y),
  .clip_w    (out_o.clip_w),
  .zero_w    (out_o.zero_w)
);
